### sv/fat_cluster_table_engine_macros.svh
// Assertion macros shared by the FAT cluster table engine RTL.
`ifndef FAT_CLUSTER_TABLE_ENGINE_MACROS_SVH
`define FAT_CLUSTER_TABLE_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define FCTE_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fcte assertion failed");
`define FCTE_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fcte assertion failed");
`else
`define FCTE_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define FCTE_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

### sv/fcte_pkg.sv
// Constants and codes of the FAT cluster table engine.
`timescale 1ns / 1ps
`default_nettype none
package fcte_pkg;
    localparam int IN_W  = 56;
    localparam int OUT_W = 40;

    localparam logic [2:0] MODE_BYTE_WR  = 3'd0;
    localparam logic [2:0] MODE_BYTE_RD  = 3'd1;
    localparam logic [2:0] MODE_ENTRY_RD = 3'd2;
    localparam logic [2:0] MODE_ENTRY_WR = 3'd3;
    localparam logic [2:0] MODE_RECOUNT  = 3'd4;
    localparam logic [2:0] MODE_ALLOC    = 3'd5;
    localparam logic [2:0] MODE_EXTEND   = 3'd6;
    localparam logic [2:0] MODE_FREE     = 3'd7;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_BOUND = 2'd2;
    localparam logic [1:0] STAT_RANGE = 2'd3;

    localparam logic [1:0] REG_WIDE = 2'd0;
    localparam logic [1:0] REG_MAX  = 2'd1;
    localparam logic [1:0] REG_SPC  = 2'd2;

    localparam logic [15:0] END_MARK  = 16'hFFFF;
    localparam logic [15:0] CHAIN_END = 16'hFFF8;
    localparam logic [11:0] WIDEN_AT  = 12'hFF0;
    localparam logic [18:0] COUNT_MAX = 19'h7FFFF;
endpackage
`default_nettype wire

### sv/fcte_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fcte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end
endmodule
`default_nettype wire

### sv/fat_cluster_table_engine.sv
// FAT cluster table engine: byte image of a FAT12/FAT16 table and its sequencer.
//
// Input beats arrive on s_tvalid/s_tready/s_tdata; one result beat per input
// leaves on m_tvalid/m_tready/m_tdata. Registers are written over the cfg_*
// channel, which is ready only while no operation is in progress.
// Every operation runs through one byte RAM port: an entry access is a range
// check and two byte reads, and an entry update adds the two byte writes.
// Recount reads each cluster from 2 to max_cluster; allocation reads each
// cluster searched, then marks the found one and links the previous one to
// it; extend reads one entry per hop first; freeing reads and clears each
// freed cluster.
// s_tready is low while an operation runs. The finished result sits in an
// output register, so when the receiver stalls the engine returns to idle and
// can take the next beat; it waits only when a second result is ready before
// the first has been taken. Reset clears the free count, the dirty flag and
// the handshakes and loads the register defaults; the image content is
// undefined until written, and there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "fat_cluster_table_engine_macros.svh"
module fat_cluster_table_engine #(
    parameter int FAT_BYTES = 8192
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // mode[2:0], byte_addr[15:3], byte_data[23:16], cluster[39:24], entry_value[55:40]
    input  wire logic [fcte_pkg::IN_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // result_value[15:0], status[17:16], free_sectors[36:18], table_dirty[37], zero[39:38]
    output logic [fcte_pkg::OUT_W-1:0]     m_tdata,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [11:0]               cfg_data
);
    import fcte_pkg::*;

    localparam int AW = $clog2(FAT_BYTES);
    localparam logic [17:0] FB18 = 18'(FAT_BYTES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BYTE  = 4'd1;
    localparam logic [3:0] S_LOOK  = 4'd2;
    localparam logic [3:0] S_RD1   = 4'd3;
    localparam logic [3:0] S_EVAL  = 4'd4;
    localparam logic [3:0] S_WR0   = 4'd5;
    localparam logic [3:0] S_WR1   = 4'd6;
    localparam logic [3:0] S_ALLOC = 4'd7;
    localparam logic [3:0] S_FTOP  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    localparam logic [2:0] PH_ERD  = 3'd0;
    localparam logic [2:0] PH_EWR  = 3'd1;
    localparam logic [2:0] PH_CNT  = 3'd2;
    localparam logic [2:0] PH_WALK = 3'd3;
    localparam logic [2:0] PH_SCAN = 3'd4;
    localparam logic [2:0] PH_LINK = 3'd5;
    localparam logic [2:0] PH_FREE = 3'd6;

    function automatic logic [17:0] entry_base(input logic [15:0] c, input logic w);
        logic [17:0] half;
        half = {3'b0, c[15:1]};
        if (w) begin
            return {1'b0, c, 1'b0};
        end
        return (half << 1) + half + {17'b0, c[0]};
    endfunction

    function automatic logic entry_ok(input logic [15:0] c, input logic w);
        logic [17:0] half;
        logic [17:0] last;
        half = {3'b0, c[15:1]};
        last = w ? {1'b0, c, 1'b1} : (half << 1) + half + 18'd2;
        return last < FB18;
    endfunction

    logic [3:0]  state_reg, state_next;
    logic [2:0]  ph_reg, ph_next;
    logic [15:0] cur_reg, cur_next;
    logic [15:0] prev_reg, prev_next;
    logic [15:0] nxt_reg, nxt_next;
    logic [15:0] wval_reg, wval_next;
    logic [12:0] cnt_reg, cnt_next;
    logic [7:0]  b0_reg, b0_next;
    logic [7:0]  b1_reg, b1_next;
    logic        oor_reg, oor_next;
    logic [15:0] res_reg, res_next;
    logic [1:0]  st_reg, st_next;
    logic [18:0] free_reg, free_next;
    logic        dirty_reg, dirty_next;
    logic        wide_reg;
    logic [11:0] max_reg;
    logic [7:0]  spc_reg;
    logic [15:0] ores_reg, ores_next;
    logic [1:0]  ost_reg, ost_next;
    logic [18:0] ofree_reg, ofree_next;
    logic        odirty_reg, odirty_next;
    logic        mval_reg, mval_next;

    logic          ram_en, ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_rdata;

    logic [2:0]  in_mode;
    logic [12:0] in_byte_addr;
    logic [7:0]  in_byte_data;
    logic [15:0] in_cluster;
    logic [15:0] in_entry_value;
    logic        s_fire;
    logic        byte_ok;
    logic [17:0] a0, a1;
    logic        cur_ok;
    logic [11:0] v12;
    logic [15:0] eval_v;
    logic [15:0] next_v;
    logic [7:0]  w0, w1;
    logic [16:0] cur_inc;
    logic [15:0] cur_wrap;
    logic [15:0] p_norm;
    logic [16:0] p_inc;
    logic [15:0] p_wrap;
    logic [11:0] limit;
    logic [12:0] cnt_inc;
    logic [19:0] free_sum;
    logic [18:0] free_add;
    logic [18:0] free_sub;

    assign in_mode        = s_tdata[2:0];
    assign in_byte_addr   = s_tdata[15:3];
    assign in_byte_data   = s_tdata[23:16];
    assign in_cluster     = s_tdata[39:24];
    assign in_entry_value = s_tdata[55:40];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = mval_reg;
    assign m_tdata   = {2'b00, odirty_reg, ofree_reg, ost_reg, ores_reg};

    assign byte_ok = {5'b0, in_byte_addr} < FB18;
    assign a0      = entry_base(cur_reg, wide_reg);
    assign a1      = a0 + 18'd1;
    assign cur_ok  = entry_ok(cur_reg, wide_reg);

    // Entry decode from the two consecutive bytes; b1 is still on the RAM output.
    always_comb begin
        v12 = cur_reg[0] ? {ram_rdata, b0_reg[7:4]} : {ram_rdata[3:0], b0_reg};
        if (oor_reg) begin
            eval_v = END_MARK;
        end else if (wide_reg) begin
            eval_v = {ram_rdata, b0_reg};
        end else if (v12 >= WIDEN_AT) begin
            eval_v = {4'hF, v12};
        end else begin
            eval_v = {4'h0, v12};
        end
        next_v = (eval_v >= CHAIN_END) ? END_MARK : eval_v;
    end

    // Bytes written back, merged with the neighboring nibble in 12-bit mode.
    always_comb begin
        if (wide_reg) begin
            w0 = wval_reg[7:0];
            w1 = wval_reg[15:8];
        end else if (cur_reg[0]) begin
            w0 = {wval_reg[3:0], b0_reg[3:0]};
            w1 = wval_reg[11:4];
        end else begin
            w0 = wval_reg[7:0];
            w1 = {b1_reg[7:4], wval_reg[11:8]};
        end
    end

    assign cur_inc  = {1'b0, cur_reg} + 17'd1;
    assign cur_wrap = (cur_inc > {5'b0, max_reg}) ? 16'd2 : cur_inc[15:0];
    assign p_norm   = (prev_reg == 16'd0 || prev_reg == END_MARK) ? 16'd1 : prev_reg;
    assign p_inc    = {1'b0, p_norm} + 17'd1;
    assign p_wrap   = (p_inc > {5'b0, max_reg}) ? 16'd2 : p_inc[15:0];
    assign limit    = (max_reg >= 12'd2) ? max_reg - 12'd1 : 12'd0;
    assign cnt_inc  = cnt_reg + 13'd1;
    assign free_sum = {1'b0, free_reg} + {12'b0, spc_reg};
    assign free_add = free_sum[19] ? COUNT_MAX : free_sum[18:0];
    assign free_sub = free_reg - {11'b0, spc_reg};

    always_comb begin
        state_next  = state_reg;
        ph_next     = ph_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        nxt_next    = nxt_reg;
        wval_next   = wval_reg;
        cnt_next    = cnt_reg;
        b0_next     = b0_reg;
        b1_next     = b1_reg;
        oor_next    = oor_reg;
        res_next    = res_reg;
        st_next     = st_reg;
        free_next   = free_reg;
        dirty_next  = dirty_reg;
        ores_next   = ores_reg;
        ost_next    = ost_reg;
        ofree_next  = ofree_reg;
        odirty_next = odirty_reg;
        mval_next   = (mval_reg && m_tready) ? 1'b0 : mval_reg;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = a0[AW-1:0];
        ram_wdata   = w0;

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    res_next  = 16'd0;
                    st_next   = STAT_OK;
                    cnt_next  = 13'd0;
                    cur_next  = in_cluster;
                    prev_next = in_cluster;
                    wval_next = in_entry_value;
                    case (in_mode)
                        MODE_BYTE_WR: begin
                            if (byte_ok) begin
                                ram_en    = 1'b1;
                                ram_we    = 1'b1;
                                ram_addr  = AW'(in_byte_addr);
                                ram_wdata = in_byte_data;
                            end else begin
                                st_next = STAT_RANGE;
                            end
                            state_next = S_DONE;
                        end
                        MODE_BYTE_RD: begin
                            if (byte_ok) begin
                                ram_en     = 1'b1;
                                ram_addr   = AW'(in_byte_addr);
                                state_next = S_BYTE;
                            end else begin
                                st_next    = STAT_RANGE;
                                state_next = S_DONE;
                            end
                        end
                        MODE_ENTRY_RD, MODE_ENTRY_WR: begin
                            if (entry_ok(in_cluster, wide_reg)) begin
                                ph_next    = (in_mode == MODE_ENTRY_RD) ? PH_ERD : PH_EWR;
                                state_next = S_LOOK;
                            end else begin
                                st_next    = STAT_RANGE;
                                state_next = S_DONE;
                            end
                        end
                        MODE_RECOUNT: begin
                            dirty_next = 1'b0;
                            free_next  = 19'd0;
                            cur_next   = 16'd2;
                            ph_next    = PH_CNT;
                            state_next = (max_reg < 12'd2) ? S_DONE : S_LOOK;
                        end
                        MODE_ALLOC: begin
                            state_next = S_ALLOC;
                        end
                        MODE_EXTEND: begin
                            ph_next    = PH_WALK;
                            state_next = (in_cluster == 16'd0) ? S_ALLOC : S_LOOK;
                        end
                        default: begin
                            state_next = S_FTOP;
                        end
                    endcase
                end
            end
            S_BYTE: begin
                res_next   = {8'b0, ram_rdata};
                state_next = S_DONE;
            end
            S_LOOK: begin
                oor_next = !cur_ok;
                if (cur_ok) begin
                    ram_en     = 1'b1;
                    state_next = S_RD1;
                end else begin
                    state_next = S_EVAL;
                end
            end
            S_RD1: begin
                b0_next    = ram_rdata;
                ram_en     = 1'b1;
                ram_addr   = a1[AW-1:0];
                state_next = S_EVAL;
            end
            S_EVAL: begin
                b1_next = ram_rdata;
                case (ph_reg)
                    PH_ERD: begin
                        res_next   = eval_v;
                        state_next = S_DONE;
                    end
                    PH_EWR: begin
                        state_next = S_WR0;
                    end
                    PH_CNT: begin
                        if (eval_v == 16'd0) begin
                            free_next = free_add;
                        end
                        cur_next   = cur_inc[15:0];
                        state_next = (cur_reg >= {4'b0, max_reg}) ? S_DONE : S_LOOK;
                    end
                    PH_WALK: begin
                        if (next_v == END_MARK) begin
                            prev_next  = cur_reg;
                            state_next = S_ALLOC;
                        end else if (cnt_reg >= {1'b0, max_reg}) begin
                            st_next    = STAT_BOUND;
                            res_next   = END_MARK;
                            state_next = S_DONE;
                        end else begin
                            cur_next   = next_v;
                            cnt_next   = cnt_inc;
                            state_next = S_LOOK;
                        end
                    end
                    PH_SCAN: begin
                        if (eval_v == 16'd0) begin
                            res_next   = cur_reg;
                            wval_next  = END_MARK;
                            free_next  = free_sub;
                            state_next = S_WR0;
                        end else if (cnt_inc == {1'b0, limit} || cur_wrap == prev_reg) begin
                            st_next    = STAT_FULL;
                            res_next   = END_MARK;
                            state_next = S_DONE;
                        end else begin
                            cnt_next   = cnt_inc;
                            cur_next   = cur_wrap;
                            state_next = S_LOOK;
                        end
                    end
                    PH_LINK: begin
                        wval_next  = res_reg;
                        state_next = oor_reg ? S_DONE : S_WR0;
                    end
                    default: begin
                        nxt_next   = next_v;
                        wval_next  = 16'd0;
                        free_next  = free_add;
                        state_next = S_WR0;
                    end
                endcase
            end
            S_WR0: begin
                ram_en     = 1'b1;
                ram_we     = 1'b1;
                dirty_next = 1'b1;
                state_next = S_WR1;
            end
            S_WR1: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = a1[AW-1:0];
                ram_wdata = w1;
                case (ph_reg)
                    PH_SCAN: begin
                        // The found cluster is marked; now link the previous one to it.
                        cur_next   = prev_reg;
                        ph_next    = PH_LINK;
                        state_next = (prev_reg >= 16'd2) ? S_LOOK : S_DONE;
                    end
                    PH_FREE: begin
                        cur_next   = nxt_reg;
                        cnt_next   = cnt_inc;
                        state_next = S_FTOP;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_ALLOC: begin
                prev_next = p_norm;
                cnt_next  = 13'd0;
                if (free_reg < {11'b0, spc_reg} || limit == 12'd0 || p_wrap == p_norm) begin
                    st_next    = STAT_FULL;
                    res_next   = END_MARK;
                    state_next = S_DONE;
                end else begin
                    cur_next   = p_wrap;
                    ph_next    = PH_SCAN;
                    state_next = S_LOOK;
                end
            end
            S_FTOP: begin
                ph_next = PH_FREE;
                if (cur_reg == END_MARK) begin
                    state_next = S_DONE;
                end else if (cnt_reg >= {1'b0, max_reg}) begin
                    st_next    = STAT_BOUND;
                    state_next = S_DONE;
                end else if (!cur_ok) begin
                    st_next    = STAT_RANGE;
                    state_next = S_DONE;
                end else begin
                    state_next = S_LOOK;
                end
            end
            S_DONE: begin
                if (!mval_reg || m_tready) begin
                    ores_next   = res_reg;
                    ost_next    = st_reg;
                    ofree_next  = free_reg;
                    odirty_next = dirty_reg;
                    mval_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            free_reg  <= 19'd0;
            dirty_reg <= 1'b0;
            mval_reg  <= 1'b0;
            wide_reg  <= 1'b0;
            max_reg   <= 12'd4095;
            spc_reg   <= 8'd2;
            cnt_reg   <= 13'd0;
        end else begin
            state_reg <= state_next;
            free_reg  <= free_next;
            dirty_reg <= dirty_next;
            mval_reg  <= mval_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WIDE: wide_reg <= cfg_data[0];
                    REG_MAX:  max_reg  <= cfg_data;
                    REG_SPC:  spc_reg  <= cfg_data[7:0];
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        ph_reg     <= ph_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        nxt_reg    <= nxt_next;
        wval_reg   <= wval_next;
        b0_reg     <= b0_next;
        b1_reg     <= b1_next;
        oor_reg    <= oor_next;
        res_reg    <= res_next;
        st_reg     <= st_next;
        ores_reg   <= ores_next;
        ost_reg    <= ost_next;
        ofree_reg  <= ofree_next;
        odirty_reg <= odirty_next;
    end

    fcte_ram #(
        .WIDTH (8),
        .DEPTH (FAT_BYTES)
    ) u_image (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    `FCTE_ASSERT_IMPL(a_write_states, aclk, aresetn, ram_we, state_reg == S_IDLE || state_reg == S_WR0 || state_reg == S_WR1)
    `FCTE_ASSERT_NEXT(a_recount_clears, aclk, aresetn, s_fire && in_mode == MODE_RECOUNT, !dirty_reg)
    `FCTE_ASSERT_IMPL(a_scan_skips_prev, aclk, aresetn, state_reg == S_EVAL && ph_reg == PH_SCAN, cur_reg != prev_reg)
    `FCTE_ASSERT_IMPL(a_hops_bounded, aclk, aresetn, state_reg != S_IDLE, cnt_reg <= {1'b0, max_reg})
endmodule
`default_nettype wire

### tb/tb_fat_cluster_table_engine.sv
// Self-checking testbench of the FAT cluster table engine with a software mirror of the table.
`timescale 1ns / 1ps
module tb_fat_cluster_table_engine;
    import fcte_pkg::*;

    localparam int IMAGE_BYTES = 8192;

    typedef struct packed {
        logic [15:0] value;
        logic [1:0]  status;
        logic [18:0] free;
        logic        dirty;
    } fat_result_t;

    // Mirror of the table image, free count and dirty flag; predicts every result beat.
    class fat_table_mirror;
        logic [7:0]  image [0:IMAGE_BYTES-1];
        bit          wide;
        int unsigned max_cl;
        int unsigned spc;
        int unsigned free_cnt;
        bit          dirty;
        fat_result_t awaited[$];
        int          errors;
        int          checked;

        function new();
            wide = 0;
            max_cl = 4095;
            spc = 2;
            free_cnt = 0;
            dirty = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [11:0] data);
            case (idx)
                REG_WIDE: wide = data[0];
                REG_MAX:  max_cl = data;
                REG_SPC:  spc = data[7:0];
                default: ;
            endcase
        endfunction

        function bit fits(int unsigned c);
            int unsigned last;
            last = wide ? 2 * c + 1 : 3 * (c >> 1) + 2;
            return last < IMAGE_BYTES;
        endfunction

        function int unsigned entry_of(int unsigned c);
            int unsigned o;
            int unsigned v;
            if (!fits(c))
                return END_MARK;
            if (wide) begin
                o = 2 * c;
                v = int'(image[o]) | (int'(image[o + 1]) << 8);
                return v;
            end
            o = 3 * (c >> 1);
            if (c[0])
                v = (int'(image[o + 1]) >> 4) | (int'(image[o + 2]) << 4);
            else
                v = int'(image[o]) | ((int'(image[o + 1]) & 'h0F) << 8);
            if (v >= WIDEN_AT)
                v |= 'hF000;
            return v;
        endfunction

        function void put_entry(int unsigned c, int unsigned v);
            int unsigned o;
            if (!fits(c))
                return;
            if (wide) begin
                o = 2 * c;
                image[o] = 8'(v);
                image[o + 1] = 8'(v >> 8);
            end else begin
                o = 3 * (c >> 1);
                if (c[0]) begin
                    image[o + 2] = 8'(v >> 4);
                    image[o + 1] = (image[o + 1] & 8'h0F) | 8'((v & 'hF) << 4);
                end else begin
                    image[o] = 8'(v);
                    image[o + 1] = (image[o + 1] & 8'hF0) | 8'((v >> 8) & 'hF);
                end
            end
            dirty = 1;
        endfunction

        function int unsigned link_of(int unsigned c);
            int unsigned v;
            v = entry_of(c);
            return v >= CHAIN_END ? END_MARK : v;
        endfunction

        function void credit_cluster();
            free_cnt += spc;
            if (free_cnt > COUNT_MAX)
                free_cnt = COUNT_MAX;
        endfunction

        function int unsigned grab_cluster(int unsigned prev, inout logic [1:0] st);
            int unsigned p;
            int unsigned i;
            int unsigned limit;
            p = prev;
            limit = max_cl >= 2 ? max_cl - 1 : 0;
            if (p == 0 || p == END_MARK)
                p = 1;
            if (free_cnt >= spc) begin
                i = p;
                for (int unsigned n = 0; n < limit; n++) begin
                    i++;
                    if (i > max_cl)
                        i = 2;
                    if (i == p)
                        break;
                    if (entry_of(i) == 0) begin
                        put_entry(i, END_MARK);
                        if (p >= 2)
                            put_entry(p, i);
                        free_cnt -= spc;
                        return i;
                    end
                end
            end
            st = STAT_FULL;
            return END_MARK;
        endfunction

        function void take_op(logic [2:0] md, logic [12:0] ad, logic [7:0] dt,
                              logic [15:0] cl, logic [15:0] vl);
            fat_result_t r;
            int unsigned c;
            int unsigned nx;
            int unsigned n;
            r = '0;
            case (md)
                MODE_BYTE_WR: image[ad] = dt;
                MODE_BYTE_RD: r.value = image[ad];
                MODE_ENTRY_RD: begin
                    if (fits(cl)) r.value = 16'(entry_of(cl));
                    else r.status = STAT_RANGE;
                end
                MODE_ENTRY_WR: begin
                    if (fits(cl)) put_entry(cl, vl);
                    else r.status = STAT_RANGE;
                end
                MODE_RECOUNT: begin
                    dirty = 0;
                    free_cnt = 0;
                    for (c = 2; c <= max_cl; c++)
                        if (entry_of(c) == 0)
                            credit_cluster();
                end
                MODE_ALLOC: r.value = 16'(grab_cluster(cl, r.status));
                MODE_EXTEND: begin
                    c = cl;
                    if (c != 0) begin
                        n = 0;
                        nx = link_of(c);
                        while (nx != END_MARK) begin
                            if (n >= max_cl) begin
                                r.status = STAT_BOUND;
                                break;
                            end
                            c = nx;
                            n++;
                            nx = link_of(c);
                        end
                    end
                    if (r.status == STAT_OK) r.value = 16'(grab_cluster(c, r.status));
                    else r.value = END_MARK;
                end
                default: begin
                    c = cl;
                    n = 0;
                    while (c != END_MARK) begin
                        if (n >= max_cl) begin
                            r.status = STAT_BOUND;
                            break;
                        end
                        if (!fits(c)) begin
                            r.status = STAT_RANGE;
                            break;
                        end
                        nx = link_of(c);
                        put_entry(c, 0);
                        credit_cluster();
                        c = nx;
                        n++;
                    end
                end
            endcase
            r.free = 19'(free_cnt);
            r.dirty = dirty;
            awaited.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [OUT_W-1:0] beat);
            fat_result_t e;
            if (awaited.size() == 0) begin
                report($sformatf("result beat %h with nothing awaited", beat));
                return;
            end
            e = awaited.pop_front();
            checked++;
            if (beat[15:0] !== e.value)
                report($sformatf("beat %0d value %h, want %h", checked, beat[15:0], e.value));
            if (beat[17:16] !== e.status)
                report($sformatf("beat %0d status %0d, want %0d", checked, beat[17:16],
                                 e.status));
            if (beat[36:18] !== e.free)
                report($sformatf("beat %0d free %0d, want %0d", checked, beat[36:18], e.free));
            if (beat[37] !== e.dirty)
                report($sformatf("beat %0d dirty %b, want %b", checked, beat[37], e.dirty));
        endtask
    endclass

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              s_tvalid = 0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 0;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_valid = 0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = REG_WIDE;
    logic [11:0]       cfg_data = '0;

    fat_table_mirror mirror = new();
    int gap_pct = 0;
    int stall_pct = 0;
    int sent = 0;

    fat_cluster_table_engine u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
        if (aresetn && m_tvalid && m_tready)
            mirror.check_result(m_tdata);
    end

    initial begin
        #200_000_000;
        $display("tb_fat_cluster_table_engine: FAIL");
        $finish;
    end

    task automatic send_op(logic [2:0] md, logic [12:0] ad, logic [7:0] dt,
                           logic [15:0] cl, logic [15:0] vl);
        s_tvalid <= 1'b1;
        s_tdata <= {vl, cl, dt, ad, md};
        do @(posedge aclk); while (!s_tready);
        mirror.take_op(md, ad, dt, cl, vl);
        sent++;
        if ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (mirror.awaited.size() != 0) @(posedge aclk);
    endtask

    // Registers go in back to back; valid stays high across the three beats.
    task automatic load_config(bit w, int unsigned mx, int unsigned sp);
        logic [11:0] vals [3];
        vals[0] = w;
        vals[1] = mx;
        vals[2] = sp;
        drain();
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            mirror.set_reg(2'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_op();
        int unsigned span;
        int unsigned r;
        logic [2:0]  md;
        logic [12:0] ad;
        logic [15:0] cl;
        logic [15:0] vl;
        span = mirror.max_cl + 3;
        r = $urandom_range(0, 99);
        md = r < 8 ? MODE_BYTE_WR : r < 14 ? MODE_BYTE_RD : r < 26 ? MODE_ENTRY_RD :
             r < 44 ? MODE_ENTRY_WR : r < 50 ? MODE_RECOUNT : r < 68 ? MODE_ALLOC :
             r < 84 ? MODE_EXTEND : MODE_FREE;
        r = $urandom_range(0, 99);
        cl = r < 80 ? 16'($urandom_range(0, span)) : r < 88 ? END_MARK : 16'($urandom);
        r = $urandom_range(0, 99);
        vl = r < 40 ? 16'($urandom_range(0, span)) : r < 55 ? 16'h0 :
             r < 70 ? 16'($urandom_range(CHAIN_END, END_MARK)) :
             r < 78 ? 16'($urandom_range(WIDEN_AT, 12'hFFF)) : 16'($urandom);
        ad = $urandom_range(0, 99) < 70 ? 13'($urandom_range(0, 2 * span)) : 13'($urandom);
        send_op(md, ad, 8'($urandom), cl, vl);
    endtask

    initial begin
        int unsigned mx;
        int unsigned sp;
        int limit;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every byte is written once so that no later walk reads unset memory.
        for (int a = 0; a < IMAGE_BYTES; a++)
            send_op(MODE_BYTE_WR, 13'(a), 8'h00, 16'h0, 16'h0);

        send_op(MODE_RECOUNT, 0, 0, 0, 0);
        send_op(MODE_BYTE_WR, 13'h1FFF, 8'hFF, 0, 0);
        send_op(MODE_BYTE_RD, 13'h1FFF, 0, 0, 0);
        send_op(MODE_BYTE_WR, 13'h1FFF, 8'h00, 0, 0);
        send_op(MODE_ENTRY_WR, 0, 0, 16'd4095, 16'h0FFF);
        send_op(MODE_ENTRY_RD, 0, 0, 16'd4095, 0);
        send_op(MODE_ENTRY_WR, 0, 0, 16'd2, 16'h0FF0);
        send_op(MODE_ENTRY_RD, 0, 0, 16'd2, 0);
        send_op(MODE_ENTRY_WR, 0, 0, 16'd3, 16'hFABC);
        send_op(MODE_ENTRY_RD, 0, 0, 16'd3, 0);
        send_op(MODE_ENTRY_RD, 0, 0, 16'hFFFF, 0);
        send_op(MODE_ENTRY_WR, 0, 0, 16'hFFFF, 16'h1234);
        send_op(MODE_ALLOC, 0, 0, 16'h0, 0);
        send_op(MODE_ALLOC, 0, 0, END_MARK, 0);
        send_op(MODE_EXTEND, 0, 0, 16'h0, 0);
        send_op(MODE_EXTEND, 0, 0, 16'd2, 0);
        send_op(MODE_FREE, 0, 0, END_MARK, 0);
        send_op(MODE_FREE, 0, 0, 16'h9000, 0);
        // A two-entry loop trips the hop bound of both chain walks.
        send_op(MODE_ENTRY_WR, 0, 0, 16'd10, 16'd11);
        send_op(MODE_ENTRY_WR, 0, 0, 16'd11, 16'd10);
        send_op(MODE_EXTEND, 0, 0, 16'd10, 0);
        send_op(MODE_FREE, 0, 0, 16'd10, 0);
        send_op(MODE_RECOUNT, 0, 0, 0, 0);

        for (int ph = 0; ph < 12; ph++) begin
            mx = ph == 5 ? 4095 : ph == 2 ? 2 : ph == 3 ? 3 : $urandom_range(4, 48);
            sp = ph % 3 == 0 ? 128 : ph % 3 == 1 ? 1 : $urandom_range(2, 127);
            load_config(ph[0], mx, sp);
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 55; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 55; end
                default: begin gap_pct = 35; stall_pct = 35; end
            endcase
            send_op(MODE_RECOUNT, 0, 0, 0, 0);
            repeat (mx == 4095 ? 15 : 180) random_op();
        end

        s_tvalid <= 1'b0;
        limit = 0;
        while (mirror.awaited.size() != 0 && limit < 400000) begin
            @(posedge aclk);
            limit++;
        end
        repeat (50) @(posedge aclk);
        if (mirror.awaited.size() != 0)
            mirror.report($sformatf("%0d results never arrived", mirror.awaited.size()));
        $display("Sent %0d operations over 12 register settings in both entry widths,",
                 sent);
        $display("with sender gaps and receiver stalls; %0d results compared.",
                 mirror.checked);
        if (mirror.errors == 0)
            $display("tb_fat_cluster_table_engine: PASS");
        else
            $display("tb_fat_cluster_table_engine: FAIL");
        $finish;
    end
endmodule

### files.f
+incdir+sv
sv/fcte_pkg.sv
sv/fcte_ram.sv
sv/fat_cluster_table_engine.sv
tb/tb_fat_cluster_table_engine.sv
